FILE: rtl/b2d_pkg.sv
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared types and constants for the 64-bit binary to decimal digit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package b2d_pkg;

    // Input word and decimal geometry
    localparam int ValueWidth    = 64;
    localparam int DigitWidth    = 4;
    localparam int NumDigits     = 20;
    // Binary bits folded into the digit chain per clock
    localparam int BitsPerStep   = 4;
    localparam int NumSteps      = ValueWidth / BitsPerStep;
    localparam int StepCntWidth  = $clog2(NumSteps);
    localparam int DigitCntWidth = $clog2(NumDigits + 1);

    typedef logic [DigitWidth-1:0]               digit_t;
    typedef logic [NumDigits-1:0][DigitWidth-1:0] digits_t;

    // Converted digits handed from the converter to the output drain
    typedef struct packed {
        logic    valid;
        digits_t digits;
    } handoff_t;

endpackage : b2d_pkg

`default_nettype wire

FILE: rtl/b2d_cell.sv
// ----------------------------------------------------------------------------
// b2d_cell
// One BCD digit of the shift-and-add-3 chain; folds four bits per clock while enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_cell (
    input  wire logic                                 aclk,
    input  wire logic                                 clear,
    input  wire logic                                 enable,
    input  wire logic [b2d_pkg::BitsPerStep-1:0]      in_bits,
    output logic      [b2d_pkg::BitsPerStep-1:0]      out_bits,
    output b2d_pkg::digit_t                           digit
);

    b2d_pkg::digit_t digit_reg;
    b2d_pkg::digit_t digit_next;

    // Four dependent add-3/shift steps, msb of the incoming group first
    always_comb begin
        b2d_pkg::digit_t d;
        b2d_pkg::digit_t adj;
        d        = digit_reg;
        out_bits = '0;
        for (int k = b2d_pkg::BitsPerStep - 1; k >= 0; k--) begin
            adj         = (d >= b2d_pkg::digit_t'(5)) ? d + b2d_pkg::digit_t'(3) : d;
            out_bits[k] = adj[b2d_pkg::DigitWidth-1];
            d           = {adj[b2d_pkg::DigitWidth-2:0], in_bits[k]};
        end
        digit_next = d;
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            digit_reg <= '0;
        end else if (enable) begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule : b2d_cell

`default_nettype wire

FILE: rtl/b2d_conv.sv
// ----------------------------------------------------------------------------
// b2d_conv
// Converter: value shift register feeding a chain of twenty digit cells.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_conv (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [b2d_pkg::ValueWidth-1:0]      s_value,
    output b2d_pkg::handoff_t                        hand,
    input  wire logic                                hand_ready
);

    localparam int Bps = b2d_pkg::BitsPerStep;
    localparam int Vw  = b2d_pkg::ValueWidth;

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [b2d_pkg::StepCntWidth-1:0]  step_reg, step_next;
    logic [Vw-1:0]                     value_reg, value_next;
    logic                              accept;
    logic [Bps-1:0]                    chain_bits [b2d_pkg::NumDigits];
    b2d_pkg::digits_t                  digits;

    // Take a new value once the previous digits are gone or leaving now
    assign s_ready = !busy_reg && (!done_reg || hand_ready);
    assign accept  = s_valid && s_ready;

    // Step control
    always_comb begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        step_next  = step_reg;
        value_next = value_reg;
        if (done_reg && hand_ready) begin
            done_next = 1'b0;
        end
        if (accept) begin
            busy_next  = 1'b1;
            step_next  = '0;
            value_next = s_value;
        end else if (busy_reg) begin
            value_next = {value_reg[Vw-Bps-1:0], {Bps{1'b0}}};
            step_next  = step_reg + 1'b1;
            if (step_reg == b2d_pkg::StepCntWidth'(b2d_pkg::NumSteps - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // Cell chain: cell 0 takes the top bits of the value, each cell feeds the next
    assign chain_bits[0] = value_reg[Vw-1:Vw-Bps];

    for (genvar i = 0; i < b2d_pkg::NumDigits; i++) begin : g_cell
        if (i < b2d_pkg::NumDigits - 1) begin : g_mid
            b2d_cell u_cell (
                .aclk     (aclk),
                .clear    (accept),
                .enable   (busy_reg),
                .in_bits  (chain_bits[i]),
                .out_bits (chain_bits[i+1]),
                .digit    (digits[i])
            );
        end else begin : g_top
            // top digit never carries out for a 64-bit value
            b2d_cell u_cell (
                .aclk     (aclk),
                .clear    (accept),
                .enable   (busy_reg),
                .in_bits  (chain_bits[i]),
                .out_bits (),
                .digit    (digits[i])
            );
        end
    end

    assign hand.valid  = done_reg;
    assign hand.digits = digits;

endmodule : b2d_conv

`default_nettype wire

FILE: rtl/b2d_drain.sv
// ----------------------------------------------------------------------------
// b2d_drain
// Output drain: walks the digits msb first, drops leading zeros, one per clock unless m_ready stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_drain (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire b2d_pkg::handoff_t                    hand,
    output logic                                      hand_ready,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic      [b2d_pkg::DigitWidth-1:0]       m_digit,
    output logic                                      m_last
);

    localparam int Nd = b2d_pkg::NumDigits;

    b2d_pkg::digits_t                   line_reg, line_next;
    logic [b2d_pkg::DigitCntWidth-1:0]  remain_reg, remain_next;
    logic                               started_reg, started_next;
    logic                               valid_reg, valid_next;
    b2d_pkg::digit_t                    digit_reg, digit_next;
    logic                               last_reg, last_next;
    logic                               pop;
    logic                               is_last;
    logic                               emit;
    b2d_pkg::digit_t                    head;

    assign head    = line_reg[Nd-1];
    assign pop     = (remain_reg != '0) && (!valid_reg || m_ready);
    assign is_last = (remain_reg == b2d_pkg::DigitCntWidth'(1));
    assign emit    = started_reg || (head != '0) || is_last;

    // Load the next set when empty or as the last position leaves
    assign hand_ready = (remain_reg == '0) || (is_last && pop);

    always_comb begin
        line_next    = line_reg;
        remain_next  = remain_reg;
        started_next = started_reg;
        valid_next   = valid_reg;
        digit_next   = digit_reg;
        last_next    = last_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (pop) begin
            line_next   = {line_reg[Nd-2:0], b2d_pkg::digit_t'(0)};
            remain_next = remain_reg - 1'b1;
            if (emit) begin
                started_next = 1'b1;
                valid_next   = 1'b1;
                digit_next   = head;
                last_next    = is_last;
            end
        end
        if (hand.valid && hand_ready) begin
            line_next    = hand.digits;
            remain_next  = b2d_pkg::DigitCntWidth'(Nd);
            started_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg  <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            remain_reg  <= remain_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg  <= line_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
    end

    assign m_valid = valid_reg;
    assign m_digit = digit_reg;
    assign m_last  = last_reg;

endmodule : b2d_drain

`default_nettype wire

FILE: rtl/binary64_to_decimal_digits_unit.sv
// ----------------------------------------------------------------------------
// binary64_to_decimal_digits_unit
// Unsigned 64-bit binary to decimal digits, msb first, one digit per beat.
// ----------------------------------------------------------------------------
// Each value beat on s_ becomes its decimal digits on m_, most significant
// first, leading zeros dropped, m_last on the final digit; zero gives one
// beat of digit 0. A chain of twenty BCD cells converts a value after its
// beat is taken (four bits per clock) and hands the digits off with the
// last fold, while the previous value's digits drain. The drain walks all
// twenty digit positions at one per clock unless m_ready stalls it; that
// walk sets the sustained rate, and the conversion overlaps it.
// ----------------------------------------------------------------------------
`default_nettype none

module binary64_to_decimal_digits_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [b2d_pkg::ValueWidth-1:0]      s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [b2d_pkg::DigitWidth-1:0]      m_digit,
    output logic                                     m_last
);

    b2d_pkg::handoff_t hand;
    logic              hand_ready;

    // Digit cell chain
    b2d_conv u_conv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .hand       (hand),
        .hand_ready (hand_ready)
    );

    // Leading-zero drop and output register
    b2d_drain u_drain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hand       (hand),
        .hand_ready (hand_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_digit    (m_digit),
        .m_last     (m_last)
    );

`ifndef SYNTHESIS
    // A digit beat is always a decimal digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit <= b2d_pkg::DigitWidth'(9)))
        else $error("digit beat out of decimal range");

    // Once a run has started, digits follow without gaps until last
    a_run_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("gap inside a digit run");

    // Converted digits hold until the drain takes them
    a_hand_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (hand.valid && !hand_ready) |=> (hand.valid && $stable(hand.digits)))
        else $error("converted digits changed before handoff");
`endif

endmodule : binary64_to_decimal_digits_unit

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and scoreboard for the 64-bit binary to decimal digit unit.
// ----------------------------------------------------------------------------
// Values go in on s_ in random bursts. Each accepted value is converted in
// the testbench to its decimal digit beats, msb first, and queued. Every digit
// beat taken on m_ is checked against the oldest queued beat. The receiver
// stalls in changing patterns, with one long hold-off that backs the unit up.
// ----------------------------------------------------------------------------

module tb;

    localparam int CycleLimit = 500000;
    localparam int TailCycles = 64;
    localparam int HoldCycles = 400;
    localparam int MaxPrints  = 40;

    typedef struct packed {
        b2d_pkg::digit_t digit;
        logic            last;
    } digit_beat_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PATTERN
    } ready_mode_t;

    // DUT signals; the inputs are known from time zero
    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [b2d_pkg::ValueWidth-1:0] s_value = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    b2d_pkg::digit_t                m_digit;
    logic                           m_last;

    logic [b2d_pkg::ValueWidth-1:0] value_q[$];
    digit_beat_t                    digits_due_q[$];

    int          total_values    = 0;
    int          values_accepted = 0;
    int          mismatch_cnt    = 0;
    int          cycle_cnt       = 0;

    // sender burst state
    int          burst_left = 0;
    int          gap_left   = 0;

    // receiver stall state
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int          mode_left   = 0;
    logic [7:0]  ready_mask  = 8'hff;
    int          hold_left   = 0;
    logic        hold_done   = 1'b0;

    binary64_to_decimal_digits_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_digit (m_digit),
        .m_last  (m_last)
    );

    // Clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run guard
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_cnt < MaxPrints)
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        mismatch_cnt = mismatch_cnt + 1;
    endtask

    // Split a value into decimal digits and queue them msb first
    function automatic void queue_decimal_digits(input logic [b2d_pkg::ValueWidth-1:0] value);
        logic [b2d_pkg::ValueWidth-1:0] rest;
        b2d_pkg::digit_t                rev[b2d_pkg::NumDigits];
        int                             n;
        digit_beat_t                    beat;
        rest = value;
        n    = 0;
        while ((n == 0 || rest != '0) && n < b2d_pkg::NumDigits) begin
            rev[n] = b2d_pkg::digit_t'(rest % 64'd10);
            rest   = rest / 64'd10;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            beat.digit = rev[k];
            beat.last  = (k == 0);
            digits_due_q.push_back(beat);
        end
    endfunction

    // Value driver: bursts of beats separated by random gaps
    always @(posedge aclk) begin : value_driver
        logic                           fire;
        logic                           next_valid;
        logic [b2d_pkg::ValueWidth-1:0] next_value;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_value <= '0;
        end else begin
            fire = s_valid && s_ready;
            if (fire) begin
                queue_decimal_digits(s_value);
                values_accepted <= values_accepted + 1;
            end
            if (!s_valid || fire) begin
                next_valid = 1'b0;
                next_value = s_value;
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (value_q.size() != 0) begin
                    next_valid = 1'b1;
                    next_value = value_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end
                s_valid <= next_valid;
                s_value <= next_value;
            end
        end
    end

    // Digit monitor: check each beat, then pick the next ready
    always @(posedge aclk) begin : digit_monitor
        digit_beat_t got;
        digit_beat_t want;
        logic        next_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.digit = m_digit;
                got.last  = m_last;
                if (digits_due_q.size() == 0) begin
                    report_mismatch("unexpected digit beat", got.digit, -1);
                end else begin
                    want = digits_due_q.pop_front();
                    if (got.digit !== want.digit)
                        report_mismatch("digit", got.digit, want.digit);
                    if (got.last !== want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end

            // switch stall pattern now and then
            if (mode_left <= 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 200);
                ready_mask = 8'($urandom_range(1, 255));
            end else begin
                mode_left = mode_left - 1;
            end

            // one long hold-off once traffic is flowing
            if (!hold_done && values_accepted >= 40) begin
                hold_left = HoldCycles;
                hold_done = 1'b1;
            end

            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                next_ready = 1'b0;
            end else begin
                case (ready_mode)
                    RDY_ALWAYS:  next_ready = 1'b1;
                    RDY_HALF:    next_ready = 1'($urandom_range(0, 1));
                    RDY_SPARSE:  next_ready = ($urandom_range(0, 3) == 0);
                    default: begin
                        next_ready = ready_mask[0];
                        ready_mask = {ready_mask[0], ready_mask[7:1]};
                    end
                endcase
            end
            m_ready <= next_ready;
        end
    end

    // Stimulus list, reset and end of run
    initial begin : stimulus
        logic [b2d_pkg::ValueWidth-1:0] pow10;
        logic [b2d_pkg::ValueWidth-1:0] r;
        int                             sel;

        // directed: extremes, digit-count edges, bit patterns
        value_q.push_back(64'd0);
        value_q.push_back(64'd1);
        value_q.push_back(64'd9);
        value_q.push_back(64'd10);
        value_q.push_back(64'd99);
        value_q.push_back(64'd100);
        value_q.push_back(64'd12345);
        value_q.push_back(64'd4294967295);
        value_q.push_back(64'h7fff_ffff_ffff_ffff);
        value_q.push_back(64'h8000_0000_0000_0000);
        value_q.push_back(64'd9999999999999999999);
        value_q.push_back(64'd10000000000000000000);
        value_q.push_back(64'd18446744073709551615);
        value_q.push_back(64'h5555_5555_5555_5555);
        value_q.push_back(64'haaaa_aaaa_aaaa_aaaa);
        value_q.push_back(64'd1234567890123456789);
        value_q.push_back(64'd9876543210);
        value_q.push_back(64'd18446744073709551606);

        // random: mixed magnitudes, powers of ten and their neighbors
        for (int i = 0; i < 292; i++) begin
            r   = {$urandom, $urandom};
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3: value_q.push_back(r);
                4, 5, 6:    value_q.push_back(r >> $urandom_range(0, 63));
                7: begin
                    pow10 = 64'd1;
                    for (int k = $urandom_range(0, 19); k > 0; k--)
                        pow10 = pow10 * 64'd10;
                    value_q.push_back(pow10 + 64'($urandom_range(0, 2)) - 64'd1);
                end
                8:       value_q.push_back(64'($urandom_range(0, 99)));
                default: value_q.push_back(64'd18446744073709551615 -
                                           64'($urandom_range(0, 1000)));
            endcase
        end
        total_values = value_q.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (values_accepted != total_values) @(posedge aclk);
        while (digits_due_q.size() != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        if (digits_due_q.size() != 0)
            report_mismatch("digit beats never delivered", 0, digits_due_q.size());

        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule : tb
